>>> hdl/kdms_pkg.sv
// kdms_pkg: opcodes, status codes, field widths and key type of the
// presorted k-d median split block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kdms_pkg;

    // opcodes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_BUILD  = 3'd2;
    localparam logic [2:0] OP_SPLIT  = 3'd3;
    localparam logic [2:0] OP_MEDIAN = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_AXIS  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;
    localparam logic [1:0] STS_RANGE = 2'd3;

    // field widths
    localparam int COORD_W = 32;
    localparam int ID_W    = 20;
    localparam int SLOT_W  = 8;
    localparam int AXIS_W  = 5;
    localparam int SIZE_W  = 9;
    localparam int DIM_W   = 6;

    // register index of the dimension register
    localparam logic REG_DIMENSION = 1'b0;

    // sort key of one point on one axis
    typedef struct packed {
        logic [COORD_W-1:0] coord;
        logic [ID_W-1:0]    id;
    } t_key;

endpackage
`default_nettype wire

>>> hdl/kdms_key_less.sv
// kdms_key_less: ordering of two points on one axis, by signed coordinate,
// then point id, then slot. Depends on kdms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kdms_key_less
    import kdms_pkg::*;
#(
    parameter int PW = 8
) (
    input  wire t_key          i_a,
    input  wire logic [PW-1:0] i_a_slot,
    input  wire t_key          i_b,
    input  wire logic [PW-1:0] i_b_slot,
    output logic               o_less
);

    // a sorts before b
    always_comb begin
        if (i_a.coord != i_b.coord) begin
            o_less = $signed(i_a.coord) < $signed(i_b.coord);
        end else if (i_a.id != i_b.id) begin
            o_less = i_a.id < i_b.id;
        end else begin
            o_less = i_a_slot < i_b_slot;
        end
    end

endmodule
`default_nettype wire

>>> hdl/kd_presorted_median_split_top.sv
// kd_presorted_median_split_top: point store with per-axis sorted slot
// lists, build, split and median query. Depends on kdms_pkg, kdms_key_less.
//
// Usage: commands arrive one per transfer on the slave stream; each gives
// exactly one result on the master stream. The dimension register sits at
// byte address 0 of the APB port and is to be written only while idle; the
// block itself does not enforce this. Command steps (M = row width MAX_DIM):
//   clear, load, unused opcodes and rejected commands: straight to the result
//   median, read: sorted list read, then coordinate and id read
//   build: for each axis in use, each rank is found by comparing one point
//     against all others, one memory read per compare
//   split: clear the side marks, mark the lower half, compact the kept rows
//     (all M coordinates of each moved row are copied), then renumber each
//     axis list in use; each store has a single read port
// One command is in work at a time; the next is taken once the result is
// handed to the output register, so a stalled receiver holds at most one
// finished result while the next command proceeds.
// Reset empties the point set and clears the built flag; the stores are not
// cleared and the dimension register returns to 32.
`timescale 1ns / 1ps
`default_nettype none
module kd_presorted_median_split_top
    import kdms_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int MAX_DIM    = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream: opcode[2:0], slot[10:3], axis[15:11],
    // coord_value[47:16], point_id[67:48], keep_left[68], zero[71:69]
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,
    // master stream: result_value[31:0], result_id[51:32], size[60:52],
    // status[62:61], zero[63]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,
    // configuration
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    localparam int PW  = $clog2(MAX_POINTS);
    localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int CAW = PW + DW;
    localparam int CDEPTH = MAX_POINTS * (2 ** DW);
    localparam int SDEPTH = (2 ** DW) * (2 ** PW);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RESP,
        ST_SO_KI, ST_SO_KL, ST_SO_JR, ST_SO_JC, ST_SO_WR,
        ST_SP_CLR, ST_SP_MR, ST_SP_MW, ST_SP_CR, ST_SP_CC, ST_SP_CPR, ST_SP_CPW,
        ST_RN_RD, ST_RN_SD, ST_RN_WR,
        ST_MR_S1, ST_MR_S2
    } t_state;

    // memories
    logic [COORD_W-1:0] r_coord_mem [CDEPTH];
    logic [ID_W-1:0]    r_id_mem    [MAX_POINTS];
    logic [PW-1:0]      r_sort_mem  [SDEPTH];
    logic               r_side_mem  [MAX_POINTS];
    logic [PW-1:0]      r_nidx_mem  [MAX_POINTS];

    logic [COORD_W-1:0] r_coord_q;
    logic [ID_W-1:0]    r_id_q;
    logic [PW-1:0]      r_sort_q;
    logic               r_side_q;
    logic [PW-1:0]      r_nidx_q;

    // memory port controls
    logic               c_we, c_re;
    logic [CAW-1:0]     c_waddr, c_raddr;
    logic [COORD_W-1:0] c_wdata;
    logic               id_we, id_re;
    logic [PW-1:0]      id_waddr, id_raddr;
    logic [ID_W-1:0]    id_wdata;
    logic               so_we, so_re;
    logic [CAW-1:0]     so_waddr, so_raddr;
    logic [PW-1:0]      so_wdata;
    logic               sd_we, sd_re;
    logic [PW-1:0]      sd_waddr, sd_raddr;
    logic               sd_wdata;
    logic               ni_we, ni_re;
    logic [PW-1:0]      ni_waddr, ni_raddr;
    logic [PW-1:0]      ni_wdata;

    // control state
    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic               r_built;
    logic [DIM_W-1:0]   r_dim;
    logic [DW-1:0]      r_ax;
    logic               r_keep;
    logic [DW-1:0]      r_a;
    logic [PW-1:0]      r_i, r_j, r_s, r_r, r_c, r_rank;
    logic [CW-1:0]      r_kept;
    t_key               r_key;
    logic [COORD_W-1:0] r_rv;
    logic [ID_W-1:0]    r_rid;
    logic [1:0]         r_st;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    // input field decode
    logic [2:0]         w_op;
    logic [SLOT_W-1:0]  w_slot;
    logic [AXIS_W-1:0]  w_axis;
    logic [COORD_W-1:0] w_val;
    logic [ID_W-1:0]    w_pid;
    logic               w_keep;
    assign w_op   = i_s_tdata[2:0];
    assign w_slot = i_s_tdata[10:3];
    assign w_axis = i_s_tdata[15:11];
    assign w_val  = i_s_tdata[47:16];
    assign w_pid  = i_s_tdata[67:48];
    assign w_keep = i_s_tdata[68];

    logic w_acc;
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_acc = i_s_tvalid && o_s_tready;

    // dimension in use and command checks
    logic [7:0]    w_dim_use;
    logic          w_ax_ok, w_ready, w_slot_ok, w_rank_ok;
    logic [PW-1:0] w_med, w_rank, w_cnt_last, w_left_last;
    logic [DW-1:0] w_dim_last;
    always_comb begin
        if (r_dim == '0) begin
            w_dim_use = 8'd1;
        end else if (32'(r_dim) > 32'(MAX_DIM)) begin
            w_dim_use = 8'(MAX_DIM);
        end else begin
            w_dim_use = 8'(r_dim);
        end
    end
    assign w_dim_last  = DW'(w_dim_use - 8'd1);
    assign w_ax_ok     = 8'(w_axis) < w_dim_use;
    assign w_ready     = r_built && (r_cnt != '0);
    assign w_slot_ok   = 32'(w_slot) < 32'(MAX_POINTS);
    assign w_med       = PW'((r_cnt - CW'(1)) >> 1);
    assign w_cnt_last  = PW'(r_cnt - CW'(1));
    assign w_left_last = w_med;
    assign w_rank      = (w_op == OP_MEDIAN) ? w_med : PW'(w_slot);
    assign w_rank_ok   = (w_op == OP_MEDIAN) || (32'(w_slot) < 32'(r_cnt));

    // sort compare: point j before point i
    logic w_less;
    t_key w_jkey;
    assign w_jkey.coord = r_coord_q;
    assign w_jkey.id    = r_id_q;
    kdms_key_less #(.PW(PW)) u_less (
        .i_a      (w_jkey),
        .i_a_slot (r_j),
        .i_b      (r_key),
        .i_b_slot (r_i),
        .o_less   (w_less)
    );

    logic w_moved;
    assign w_moved = PW'(r_kept) != r_s;

    // memory port steering
    always_comb begin
        c_we = 1'b0;  c_re = 1'b0;  c_waddr = '0;  c_raddr = '0;  c_wdata = '0;
        id_we = 1'b0; id_re = 1'b0; id_waddr = '0; id_raddr = '0; id_wdata = '0;
        so_we = 1'b0; so_re = 1'b0; so_waddr = '0; so_raddr = '0; so_wdata = '0;
        sd_we = 1'b0; sd_re = 1'b0; sd_waddr = '0; sd_raddr = '0; sd_wdata = 1'b0;
        ni_we = 1'b0; ni_re = 1'b0; ni_waddr = '0; ni_raddr = '0; ni_wdata = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && w_op == OP_LOAD && w_ax_ok && w_slot_ok) begin
                    c_we     = 1'b1;
                    c_waddr  = {PW'(w_slot), DW'(w_axis)};
                    c_wdata  = w_val;
                    id_we    = 1'b1;
                    id_waddr = PW'(w_slot);
                    id_wdata = w_pid;
                end
                if (w_acc && (w_op == OP_MEDIAN || w_op == OP_READ)) begin
                    so_re    = 1'b1;
                    so_raddr = {DW'(w_axis), w_rank};
                end
            end
            ST_SO_KI: begin
                c_re = 1'b1;  c_raddr = {r_i, r_a};
                id_re = 1'b1; id_raddr = r_i;
            end
            ST_SO_JR: begin
                c_re = 1'b1;  c_raddr = {r_j, r_a};
                id_re = 1'b1; id_raddr = r_j;
            end
            ST_SO_WR: begin
                so_we = 1'b1; so_waddr = {r_a, r_rank}; so_wdata = r_i;
            end
            ST_SP_CLR: begin
                sd_we = 1'b1; sd_waddr = r_s; sd_wdata = 1'b0;
            end
            ST_SP_MR: begin
                so_re = 1'b1; so_raddr = {r_ax, r_r};
            end
            ST_SP_MW: begin
                sd_we = 1'b1; sd_waddr = r_sort_q; sd_wdata = 1'b1;
            end
            ST_SP_CR: begin
                sd_re = 1'b1; sd_raddr = r_s;
                id_re = 1'b1; id_raddr = r_s;
            end
            ST_SP_CC: begin
                if (r_side_q == r_keep) begin
                    ni_we = 1'b1; ni_waddr = r_s; ni_wdata = PW'(r_kept);
                    if (w_moved) begin
                        id_we = 1'b1; id_waddr = PW'(r_kept); id_wdata = r_id_q;
                    end
                end
            end
            ST_SP_CPR: begin
                c_re = 1'b1; c_raddr = {r_s, r_a};
            end
            ST_SP_CPW: begin
                c_we = 1'b1; c_waddr = {PW'(r_kept), r_a}; c_wdata = r_coord_q;
            end
            ST_RN_RD: begin
                so_re = 1'b1; so_raddr = {r_a, r_r};
            end
            ST_RN_SD: begin
                sd_re = 1'b1; sd_raddr = r_sort_q;
                ni_re = 1'b1; ni_raddr = r_sort_q;
            end
            ST_RN_WR: begin
                if (r_side_q == r_keep) begin
                    so_we = 1'b1; so_waddr = {r_a, r_c}; so_wdata = r_nidx_q;
                end
            end
            ST_MR_S1: begin
                c_re = 1'b1;  c_raddr = {r_sort_q, r_ax};
                id_re = 1'b1; id_raddr = r_sort_q;
            end
            default: begin
            end
        endcase
    end

    // coordinate store
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_coord_mem[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_coord_q <= r_coord_mem[c_raddr];
        end
    end

    // id store
    always_ff @(posedge i_clk) begin
        if (id_we) begin
            r_id_mem[id_waddr] <= id_wdata;
        end
        if (id_re) begin
            r_id_q <= r_id_mem[id_raddr];
        end
    end

    // sorted slot lists
    always_ff @(posedge i_clk) begin
        if (so_we) begin
            r_sort_mem[so_waddr] <= so_wdata;
        end
        if (so_re) begin
            r_sort_q <= r_sort_mem[so_raddr];
        end
    end

    // side marks
    always_ff @(posedge i_clk) begin
        if (sd_we) begin
            r_side_mem[sd_waddr] <= sd_wdata;
        end
        if (sd_re) begin
            r_side_q <= r_side_mem[sd_raddr];
        end
    end

    // renumbering table
    always_ff @(posedge i_clk) begin
        if (ni_we) begin
            r_nidx_mem[ni_waddr] <= ni_wdata;
        end
        if (ni_re) begin
            r_nidx_q <= r_nidx_mem[ni_raddr];
        end
    end

    // configuration port
    logic w_cfg_wr;
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_DIMENSION);
    assign o_prdata = (i_paddr[2] == REG_DIMENSION) ? 32'(r_dim) : 32'd0;

    // output stage
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // sequencer with registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_built     <= 1'b0;
            r_dim       <= DIM_W'(32);
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && r_state != ST_RESP) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_dim   <= i_pwdata[DIM_W-1:0];
                r_built <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_rv   <= '0;
                        r_rid  <= '0;
                        r_ax   <= DW'(w_axis);
                        r_keep <= w_keep;
                        case (w_op)
                            OP_CLEAR: begin
                                r_cnt   <= '0;
                                r_built <= 1'b0;
                                r_st    <= STS_OK;
                                r_state <= ST_RESP;
                            end
                            OP_LOAD: begin
                                r_built <= 1'b0;
                                r_state <= ST_RESP;
                                if (!w_ax_ok) begin
                                    r_st <= STS_AXIS;
                                end else if (!w_slot_ok) begin
                                    r_st <= STS_RANGE;
                                end else begin
                                    r_st <= STS_OK;
                                    if (32'(w_slot) >= 32'(r_cnt)) begin
                                        r_cnt <= CW'(32'(w_slot) + 32'd1);
                                    end
                                end
                            end
                            OP_BUILD: begin
                                if (r_cnt == '0) begin
                                    r_st    <= STS_EMPTY;
                                    r_state <= ST_RESP;
                                end else begin
                                    r_st    <= STS_OK;
                                    r_a     <= '0;
                                    r_i     <= '0;
                                    r_state <= ST_SO_KI;
                                end
                            end
                            OP_SPLIT: begin
                                if (!w_ax_ok) begin
                                    r_st    <= STS_AXIS;
                                    r_state <= ST_RESP;
                                end else if (!w_ready) begin
                                    r_st    <= STS_EMPTY;
                                    r_state <= ST_RESP;
                                end else begin
                                    r_st    <= STS_OK;
                                    r_s     <= '0;
                                    r_state <= ST_SP_CLR;
                                end
                            end
                            OP_MEDIAN, OP_READ: begin
                                if (!w_ax_ok) begin
                                    r_st    <= STS_AXIS;
                                    r_state <= ST_RESP;
                                end else if (!w_ready) begin
                                    r_st    <= STS_EMPTY;
                                    r_state <= ST_RESP;
                                end else if (!w_rank_ok) begin
                                    r_st    <= STS_RANGE;
                                    r_state <= ST_RESP;
                                end else begin
                                    r_st    <= STS_OK;
                                    r_state <= ST_MR_S1;
                                end
                            end
                            default: begin
                                r_st    <= STS_OK;
                                r_state <= ST_RESP;
                            end
                        endcase
                    end
                end
                // build: rank of point i on axis a by counting predecessors
                ST_SO_KI: r_state <= ST_SO_KL;
                ST_SO_KL: begin
                    r_key.coord <= r_coord_q;
                    r_key.id    <= r_id_q;
                    r_j         <= '0;
                    r_rank      <= '0;
                    r_state     <= ST_SO_JR;
                end
                ST_SO_JR: r_state <= ST_SO_JC;
                ST_SO_JC: begin
                    if (w_less) begin
                        r_rank <= r_rank + PW'(1);
                    end
                    if (r_j == w_cnt_last) begin
                        r_state <= ST_SO_WR;
                    end else begin
                        r_j     <= r_j + PW'(1);
                        r_state <= ST_SO_JR;
                    end
                end
                ST_SO_WR: begin
                    if (r_i == w_cnt_last) begin
                        r_i <= '0;
                        if (r_a == w_dim_last) begin
                            r_built <= 1'b1;
                            r_state <= ST_RESP;
                        end else begin
                            r_a     <= r_a + DW'(1);
                            r_state <= ST_SO_KI;
                        end
                    end else begin
                        r_i     <= r_i + PW'(1);
                        r_state <= ST_SO_KI;
                    end
                end
                // split: clear marks, then mark the lower half
                ST_SP_CLR: begin
                    if (r_s == w_cnt_last) begin
                        r_r     <= '0;
                        r_state <= ST_SP_MR;
                    end else begin
                        r_s <= r_s + PW'(1);
                    end
                end
                ST_SP_MR: r_state <= ST_SP_MW;
                ST_SP_MW: begin
                    if (r_r == w_left_last) begin
                        r_s     <= '0;
                        r_kept  <= '0;
                        r_state <= ST_SP_CR;
                    end else begin
                        r_r     <= r_r + PW'(1);
                        r_state <= ST_SP_MR;
                    end
                end
                // compaction of kept slots
                ST_SP_CR: r_state <= ST_SP_CC;
                ST_SP_CC: begin
                    if (r_side_q == r_keep && w_moved) begin
                        r_a     <= '0;
                        r_state <= ST_SP_CPR;
                    end else begin
                        if (r_side_q == r_keep) begin
                            r_kept <= r_kept + CW'(1);
                        end
                        if (r_s == w_cnt_last) begin
                            r_a     <= '0;
                            r_r     <= '0;
                            r_c     <= '0;
                            r_state <= ST_RN_RD;
                        end else begin
                            r_s     <= r_s + PW'(1);
                            r_state <= ST_SP_CR;
                        end
                    end
                end
                ST_SP_CPR: r_state <= ST_SP_CPW;
                ST_SP_CPW: begin
                    if (r_a == DW'(MAX_DIM - 1)) begin
                        r_kept <= r_kept + CW'(1);
                        if (r_s == w_cnt_last) begin
                            r_a     <= '0;
                            r_r     <= '0;
                            r_c     <= '0;
                            r_state <= ST_RN_RD;
                        end else begin
                            r_s     <= r_s + PW'(1);
                            r_state <= ST_SP_CR;
                        end
                    end else begin
                        r_a     <= r_a + DW'(1);
                        r_state <= ST_SP_CPR;
                    end
                end
                // renumber each axis list in use, in place
                ST_RN_RD: r_state <= ST_RN_SD;
                ST_RN_SD: r_state <= ST_RN_WR;
                ST_RN_WR: begin
                    if (r_r == w_cnt_last) begin
                        r_r <= '0;
                        r_c <= '0;
                        if (r_a == w_dim_last) begin
                            r_cnt   <= r_kept;
                            r_built <= (r_kept != '0);
                            r_state <= ST_RESP;
                        end else begin
                            r_a     <= r_a + DW'(1);
                            r_state <= ST_RN_RD;
                        end
                    end else begin
                        if (r_side_q == r_keep) begin
                            r_c <= r_c + PW'(1);
                        end
                        r_r     <= r_r + PW'(1);
                        r_state <= ST_RN_RD;
                    end
                end
                // median and read lookup
                ST_MR_S1: r_state <= ST_MR_S2;
                ST_MR_S2: begin
                    r_rv    <= r_coord_q;
                    r_rid   <= r_id_q;
                    r_state <= ST_RESP;
                end
                // hand the result to the output register
                ST_RESP: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {1'b0, r_st, SIZE_W'(r_cnt), r_rid, r_rv};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(MAX_POINTS))
        else $error("point count above capacity");

    a_built_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> (r_cnt != '0))
        else $error("built flag set with no points");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != ST_IDLE))
        else $error("command accepted without leaving idle");

    a_sort_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SO_KI) |-> (32'(r_i) < 32'(r_cnt)))
        else $error("sort index beyond point count");

endmodule
`default_nettype wire

>>> bench/kdms_checker.sv
// kdms_checker: watches the command, result and configuration ports of the
// presorted k-d median split block, predicts each result and compares.
// Depends on kdms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kdms_checker
    import kdms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [71:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [63:0] i_m_tdata,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic [1:0]         status;
        logic [SIZE_W-1:0]  size;
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] value;
    } kd_result_t;

    // model copy of the point store and sorted lists
    logic signed [COORD_W-1:0] pt_coord [256][32];
    logic [ID_W-1:0]           pt_id [256];
    logic [7:0]                axis_order [32][256];
    bit                        side_left [256];
    logic [7:0]                renum [256];
    int unsigned               npts;
    bit                        built;
    logic [DIM_W-1:0]          dim_reg;

    kd_result_t expected_results [$];

    function automatic int unsigned dim_in_effect();
        if (dim_reg == 0) return 1;
        if (dim_reg > 32) return 32;
        return dim_reg;
    endfunction

    // coordinate first, then id, then slot number
    function automatic bit slot_precedes(int unsigned a, int unsigned b, int unsigned ax);
        if (pt_coord[a][ax] != pt_coord[b][ax]) return pt_coord[a][ax] < pt_coord[b][ax];
        if (pt_id[a] != pt_id[b]) return pt_id[a] < pt_id[b];
        return a < b;
    endfunction

    task automatic sort_axis(input int unsigned ax);
        int unsigned j;
        for (int unsigned i = 0; i < npts; i++) begin
            j = i;
            while (j > 0 && slot_precedes(i, axis_order[ax][j-1], ax)) begin
                axis_order[ax][j] = axis_order[ax][j-1];
                j--;
            end
            axis_order[ax][j] = 8'(i);
        end
    endtask

    // mark lower half on the axis, compact kept rows, renumber every list in use
    task automatic split_points(input int unsigned ax, input bit keep_left);
        int unsigned n, left, kept, c, sl;
        n    = npts;
        left = (n + 1) / 2;
        kept = 0;
        for (int unsigned s = 0; s < n; s++) side_left[s] = 0;
        for (int unsigned r = 0; r < left; r++) side_left[axis_order[ax][r]] = 1;
        for (int unsigned s = 0; s < n; s++) begin
            if (side_left[s] == keep_left) begin
                renum[s] = 8'(kept);
                if (kept != s) begin
                    for (int a = 0; a < 32; a++) pt_coord[kept][a] = pt_coord[s][a];
                    pt_id[kept] = pt_id[s];
                end
                kept++;
            end
        end
        for (int unsigned a = 0; a < dim_in_effect(); a++) begin
            c = 0;
            for (int unsigned r = 0; r < n; r++) begin
                sl = axis_order[a][r];
                if (side_left[sl] == keep_left) begin
                    axis_order[a][c] = renum[sl];
                    c++;
                end
            end
        end
        npts  = kept;
        built = (kept > 0);
    endtask

    task automatic kd_predict(input logic [71:0] cmd, output kd_result_t res);
        logic [2:0]  op;
        int unsigned slot, ax, d, rank, sl;
        bit          ax_ok, ready;
        op    = cmd[2:0];
        slot  = cmd[10:3];
        ax    = cmd[15:11];
        d     = dim_in_effect();
        ax_ok = ax < d;
        ready = built && npts > 0;
        res   = '0;
        case (op)
            OP_CLEAR: begin
                npts  = 0;
                built = 0;
            end
            OP_LOAD: begin
                built = 0;
                if (!ax_ok) res.status = STS_AXIS;
                else begin
                    pt_coord[slot][ax] = cmd[47:16];
                    pt_id[slot]        = cmd[67:48];
                    if (slot >= npts) npts = slot + 1;
                end
            end
            OP_BUILD: begin
                if (npts == 0) res.status = STS_EMPTY;
                else begin
                    for (int unsigned a = 0; a < d; a++) sort_axis(a);
                    built = 1;
                end
            end
            OP_SPLIT: begin
                if (!ax_ok) res.status = STS_AXIS;
                else if (!ready) res.status = STS_EMPTY;
                else split_points(ax, cmd[68]);
            end
            OP_MEDIAN, OP_READ: begin
                rank = (op == OP_MEDIAN) ? (npts + 1) / 2 - 1 : slot;
                if (!ax_ok) res.status = STS_AXIS;
                else if (!ready) res.status = STS_EMPTY;
                else if (rank >= npts) res.status = STS_RANGE;
                else begin
                    sl        = axis_order[ax][rank];
                    res.value = pt_coord[sl][ax];
                    res.id    = pt_id[sl];
                end
            end
            default: ;
        endcase
        res.size = SIZE_W'(npts);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result mismatch on %s: got %0h, want %0h", $realtime, what, got,
                 want);
        o_errors++;
    endtask

    // command transfers are predicted before result transfers are matched
    always @(posedge i_clk) begin
        kd_result_t want, got;
        if (!i_rst_n) begin
            npts    = 0;
            built   = 0;
            dim_reg = 6'd32;
            expected_results.delete();
            o_pending = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == 3'(4 * REG_DIMENSION)) begin
                dim_reg = i_pwdata[DIM_W-1:0];
                built   = 0;
            end
            if (i_s_tvalid && i_s_tready) begin
                kd_predict(i_s_tdata, want);
                expected_results.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[62:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", i_m_tdata[31:0], 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value) report_mismatch("value", got.value, want.value);
                    if (got.id !== want.id) report_mismatch("id", got.id, want.id);
                    if (got.size !== want.size) report_mismatch("size", got.size, want.size);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule
`default_nettype wire

>>> bench/tb_kd_presorted_median_split_top.sv
// tb_kd_presorted_median_split_top: command stimulus, idle patterns and verdict
// for kd_presorted_median_split_top. Depends on kdms_pkg and kdms_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_kd_presorted_median_split_top;
    import kdms_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [63:0] o_m_tdata;
    logic        i_psel = 0;
    logic        i_penable = 0;
    logic        i_pwrite = 0;
    logic [2:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    int errors, pending;
    int idle_pct = 0, stall_pct = 0;
    int cycles = 0;

    // stimulus side copy of count, built flag and rows fully written
    int unsigned g_count, g_filled, g_dim;
    bit          g_built;

    kd_presorted_median_split_top dut (.*);

    kdms_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite), .i_pready(o_pready),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver stalls
    always @(posedge i_clk) i_m_tready <= ($urandom_range(99) >= stall_pct);

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'(int'($urandom_range(6)) - 3) << 16;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [19:0] pick_id();
        case ($urandom_range(3))
            0: return 20'h0;
            1: return 20'hfffff;
            default: return 20'($urandom());
        endcase
    endfunction

    // one command transfer with random idle before it
    task automatic issue(input logic [2:0] op, input logic [7:0] slot, input logic [4:0] ax,
                         input logic [31:0] val, input logic [19:0] pid, input bit kl);
        int unsigned kept;
        case (op)
            OP_CLEAR: begin g_count = 0; g_built = 0; end
            OP_LOAD: begin
                g_built = 0;
                if (ax < g_dim && slot >= g_count) g_count = slot + 1;
            end
            OP_BUILD: if (g_count > 0) g_built = 1;
            OP_SPLIT: if (ax < g_dim && g_built && g_count > 0) begin
                kept    = kl ? (g_count + 1) / 2 : g_count / 2;
                g_count = kept;
                g_built = kept > 0;
            end
            default: ;
        endcase
        if ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= {3'b000, kl, pid, val, ax, slot, op};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic issue_query(input logic [2:0] op, input logic [7:0] slot,
                               input logic [4:0] ax);
        issue(op, slot, ax, $urandom(), 20'($urandom()), 1'($urandom()));
    endtask

    task automatic load_row(input int unsigned slot);
        logic [19:0] pid;
        pid = pick_id();
        for (int unsigned a = 0; a < g_dim; a++)
            issue(OP_LOAD, 8'(slot), 5'(a), pick_coord(),
                  ($urandom_range(9) == 0) ? pick_id() : pid, 1'($urandom()));
    endtask

    // wait for every result, then write the dimension register
    task automatic write_dimension(input logic [31:0] value);
        i_s_tvalid <= 0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        i_psel    <= 1;
        i_pwrite  <= 1;
        i_penable <= 0;
        i_paddr   <= 3'(4 * REG_DIMENSION);
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1;
        @(posedge i_clk);
        i_psel    <= 0;
        i_penable <= 0;
        i_pwrite  <= 0;
        g_built = 0;
        g_dim   = (value[5:0] == 0) ? 1 : (value[5:0] > 32) ? 32 : value[5:0];
    endtask

    task automatic set_mode(input int m);
        case (m)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 30; stall_pct = 30; end
        endcase
    endtask

    function automatic logic [4:0] pick_axis();
        return ($urandom_range(99) < 85) ? 5'($urandom_range(g_dim - 1)) : 5'($urandom());
    endfunction

    // one setting: fresh rows, build, then a random mix
    task automatic run_phase(input logic [5:0] dim_raw, input int n, input int cap,
                             input int nrand, input bit heavy, input int m);
        int r;
        write_dimension({26'($urandom()), dim_raw});
        set_mode(m);
        issue_query(OP_CLEAR, 8'($urandom()), 5'($urandom()));
        g_filled = 0;
        for (int i = 0; i < n; i++) begin
            load_row(g_filled);
            g_filled++;
        end
        issue_query(OP_BUILD, 8'($urandom()), 5'($urandom()));
        for (int i = 0; i < nrand; i++) begin
            r = $urandom_range(99);
            if (heavy && r >= 60) r = r % 50;
            if (r < 25) issue_query(OP_MEDIAN, 8'($urandom()), pick_axis());
            else if (r < 50)
                issue_query(OP_READ, ($urandom_range(9) < 8) ?
                            8'($urandom_range(g_count + 1 > 255 ? 255 : g_count + 1)) :
                            8'($urandom()), pick_axis());
            else if (r < 60) issue(OP_SPLIT, 8'($urandom()), pick_axis(), $urandom(),
                                   20'($urandom()), 1'($urandom()));
            else if (r < 75) begin
                if (g_filled < cap && $urandom_range(1)) begin
                    load_row(g_filled);
                    g_filled++;
                end else
                    issue(OP_LOAD, 8'($urandom_range(g_filled - 1)), pick_axis(),
                          pick_coord(), pick_id(), 1'($urandom()));
            end else if (r < 85) issue_query(OP_BUILD, 8'($urandom()), 5'($urandom()));
            else if (r < 90) issue_query(3'($urandom_range(7, 6)), 8'($urandom()),
                                         5'($urandom()));
            else if (r < 93) issue_query(OP_CLEAR, 8'($urandom()), 5'($urandom()));
            else begin
                // bring back every written row and rebuild
                issue(OP_LOAD, 8'(g_filled - 1), 5'd0, pick_coord(), pick_id(), 1'b0);
                issue_query(OP_BUILD, 8'($urandom()), 5'($urandom()));
            end
        end
    endtask

    initial begin
        g_dim = 32; g_count = 0; g_built = 0; g_filled = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty store, unused opcodes, ties, extremes, splits to empty
        write_dimension(32'd2);
        issue_query(OP_MEDIAN, 8'd0, 5'd0);
        issue_query(OP_BUILD, 8'd0, 5'd0);
        issue(OP_SPLIT, 8'd0, 5'd0, 32'h0, 20'h0, 1'b1);
        issue_query(OP_READ, 8'd0, 5'd1);
        issue_query(3'd6, 8'hff, 5'h1f);
        issue_query(3'd7, 8'h00, 5'h00);
        issue(OP_LOAD, 8'd0, 5'd2, 32'h1234_5678, 20'h1, 1'b0);
        issue(OP_LOAD, 8'd0, 5'd0, 32'h7fff_ffff, 20'hfffff, 1'b0);
        issue(OP_LOAD, 8'd0, 5'd1, 32'h0, 20'hfffff, 1'b0);
        issue(OP_LOAD, 8'd1, 5'd0, 32'h8000_0000, 20'h0, 1'b1);
        issue(OP_LOAD, 8'd1, 5'd1, 32'h0, 20'h0, 1'b1);
        issue(OP_LOAD, 8'd2, 5'd0, 32'h7fff_ffff, 20'h0, 1'b0);
        issue(OP_LOAD, 8'd2, 5'd1, 32'h0, 20'h0, 1'b0);
        g_filled = 3;
        issue_query(OP_MEDIAN, 8'd0, 5'd0);
        issue_query(OP_BUILD, 8'd0, 5'd0);
        issue_query(OP_MEDIAN, 8'd0, 5'd0);
        issue_query(OP_MEDIAN, 8'd0, 5'd5);
        issue_query(OP_READ, 8'd2, 5'd1);
        issue_query(OP_READ, 8'd3, 5'd0);
        issue_query(OP_READ, 8'd255, 5'd0);
        issue(OP_SPLIT, 8'd0, 5'd1, 32'h0, 20'h0, 1'b1);
        issue_query(OP_MEDIAN, 8'd0, 5'd1);
        issue(OP_SPLIT, 8'd0, 5'd0, 32'h0, 20'h0, 1'b1);
        issue(OP_SPLIT, 8'd0, 5'd0, 32'h0, 20'h0, 1'b0);
        issue_query(OP_MEDIAN, 8'd0, 5'd0);

        // full store on one axis, then mixed settings
        run_phase(6'd0, 256, 256, 40, 1'b1, 0);
        run_phase(6'd32, 2, 3, 25, 1'b0, 1);
        run_phase(6'd63, 2, 3, 20, 1'b0, 2);
        run_phase(6'd5, 6, 10, 45, 1'b0, 3);
        run_phase(6'd3, 8, 14, 40, 1'b0, 1);
        run_phase(6'd1, 10, 20, 30, 1'b0, 2);
        run_phase(6'd4, 6, 10, 25, 1'b0, 0);

        i_s_tvalid <= 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
